### rtl/prst_pkg.sv
package prst_pkg;

    // Largest ring the block handles, in bytes.
    localparam int unsigned BUF_MAX = 65536;

    localparam int SIZE_W    = 17;
    localparam int OFF_W     = 16;
    localparam int CNT_W     = 17;
    localparam int FREE_W    = 18;
    localparam int PLAY_W    = 32;
    localparam int XFER_W    = 19;
    localparam int ADDR_W    = 24;
    localparam int LEN_W     = 20;
    localparam int SAMP_W    = 3;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int FUNC_W    = 3;
    localparam int FILL_W    = 8;
    localparam int SUM_W     = 20;
    localparam int DIV_W     = 27;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [SIZE_W-1:0] BUF_MAX_V = SIZE_W'(BUF_MAX);

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FN_REOPEN = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POS    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FILL   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAGMENT_BYTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAPPED_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_SAMPLES   = 3'd5;

    localparam logic signed [SUM_W-1:0] FREE_MAX = 20'sd131071;
    localparam logic signed [SUM_W-1:0] FREE_MIN = -20'sd131072;
    localparam logic [CNT_W:0]          SIL_MAX  = 18'd131071;

    // Silence bytes: signed 16-bit audio idles at zero, unsigned 8-bit at mid-scale.
    localparam logic [FILL_W-1:0] FILL_WIDE   = 8'h00;
    localparam logic [FILL_W-1:0] FILL_NARROW = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LAUNCH,
        ST_WAIT,
        ST_PREP,
        ST_COMMIT
    } t_state;

    // Which quantity the shared divider is working on.
    typedef enum logic [1:0] {
        JOB_OLD,
        JOB_SPOS,
        JOB_QUOT,
        JOB_WRAP
    } t_job;

    typedef struct packed {
        logic load;
        logic div_start;
        t_job job;
        logic capture;
        logic prep;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              running;
        logic              div_done;
    } t_stat;

    function automatic logic [SIZE_W-1:0] clamp_len(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > BUF_MAX_V) begin
            r = BUF_MAX_V;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [FREE_W-1:0] sat_free(input logic signed [SUM_W-1:0] v);
        logic signed [FREE_W-1:0] r;
        if (v > FREE_MAX) begin
            r = FREE_MAX[FREE_W-1:0];
        end else if (v < FREE_MIN) begin
            r = FREE_MIN[FREE_W-1:0];
        end else begin
            r = v[FREE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_sil(input logic [CNT_W:0] v);
        logic [CNT_W-1:0] r;
        if (v > SIL_MAX) begin
            r = SIL_MAX[CNT_W-1:0];
        end else begin
            r = v[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/prst_div.sv
module prst_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [prst_pkg::DIV_W-1:0]    i_dividend,
    input  logic [prst_pkg::SIZE_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [prst_pkg::DIV_W-1:0]    o_quot,
    output logic [prst_pkg::SIZE_W-1:0]   o_rem
);

    logic                              r_busy;
    logic                              r_done;
    logic [prst_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [prst_pkg::DIV_W-1:0]        r_quo;
    logic [prst_pkg::SIZE_W-1:0]       r_rem;
    logic [prst_pkg::SIZE_W-1:0]       r_dsr;

    logic [prst_pkg::SIZE_W:0]         rem_sh;
    logic                              ge;
    logic [prst_pkg::SIZE_W:0]         rem_nx;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        rem_sh = {r_rem, r_quo[prst_pkg::DIV_W-1]};
        ge     = (rem_sh >= {1'b0, r_dsr});
        rem_nx = ge ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= prst_pkg::DIV_CNT_W'(prst_pkg::DIV_W - 1);
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - prst_pkg::DIV_CNT_W'(1);
            r_quo <= {r_quo[prst_pkg::DIV_W-2:0], ge};
            r_rem <= rem_nx[prst_pkg::SIZE_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

### rtl/prst_ctrl.sv
module prst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  prst_pkg::t_stat   i_stat,
    output prst_pkg::t_cmd    o_cmd
);

    prst_pkg::t_state r_state, n_state;
    prst_pkg::t_job   r_job, n_job;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        case (r_state)
            prst_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = prst_pkg::ST_DECODE;
                end
            end
            prst_pkg::ST_DECODE: begin
                case (i_stat.func)
                    prst_pkg::FN_POS, prst_pkg::FN_QUERY: begin
                        n_job   = prst_pkg::JOB_OLD;
                        n_state = prst_pkg::ST_LAUNCH;
                    end
                    prst_pkg::FN_WRITE, prst_pkg::FN_FILL: begin
                        n_job   = prst_pkg::JOB_SPOS;
                        n_state = prst_pkg::ST_LAUNCH;
                    end
                    default: begin
                        n_state = prst_pkg::ST_COMMIT;
                    end
                endcase
            end
            prst_pkg::ST_LAUNCH: begin
                n_state = prst_pkg::ST_WAIT;
            end
            prst_pkg::ST_WAIT: begin
                if (i_stat.div_done) begin
                    case (r_job)
                        prst_pkg::JOB_OLD: begin
                            if ((i_stat.func == prst_pkg::FN_POS) && i_stat.running) begin
                                n_job   = prst_pkg::JOB_QUOT;
                                n_state = prst_pkg::ST_LAUNCH;
                            end else begin
                                n_state = prst_pkg::ST_COMMIT;
                            end
                        end
                        prst_pkg::JOB_QUOT, prst_pkg::JOB_SPOS: begin
                            n_state = prst_pkg::ST_PREP;
                        end
                        default: begin
                            n_state = prst_pkg::ST_COMMIT;
                        end
                    endcase
                end
            end
            prst_pkg::ST_PREP: begin
                n_job   = prst_pkg::JOB_WRAP;
                n_state = prst_pkg::ST_LAUNCH;
            end
            prst_pkg::ST_COMMIT: begin
                if (out_free) begin
                    n_state = prst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = prst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.job       = r_job;
        o_cmd.load      = (r_state == prst_pkg::ST_IDLE) && i_in_valid;
        o_cmd.div_start = (r_state == prst_pkg::ST_LAUNCH);
        o_cmd.capture   = (r_state == prst_pkg::ST_WAIT) && i_stat.div_done;
        o_cmd.prep      = (r_state == prst_pkg::ST_PREP);
        o_cmd.commit    = (r_state == prst_pkg::ST_COMMIT) && out_free;
        o_in_stall      = (r_state != prst_pkg::ST_IDLE);
        n_out_valid     = o_cmd.commit || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prst_pkg::ST_IDLE;
            r_job       <= prst_pkg::JOB_OLD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/prst_datapath.sv
module prst_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [prst_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [prst_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic [prst_pkg::FUNC_W-1:0]        i_func,
    input  logic                               i_running,
    input  logic [prst_pkg::ADDR_W-1:0]        i_hw_addr,
    input  logic [prst_pkg::LEN_W-1:0]         i_write_len,
    input  prst_pkg::t_cmd                     i_cmd,
    output prst_pkg::t_stat                    o_stat,
    output logic signed [prst_pkg::XFER_W-1:0] o_xfer_size,
    output logic                               o_need_silence,
    output logic                               o_underrun,
    output logic [prst_pkg::SIZE_W-1:0]        o_accepted_len,
    output logic [prst_pkg::OFF_W-1:0]         o_seg_start,
    output logic [prst_pkg::SIZE_W-1:0]        o_seg_first_len,
    output logic [prst_pkg::SIZE_W-1:0]        o_seg_second_len,
    output logic [prst_pkg::FILL_W-1:0]        o_fill_byte,
    output logic [prst_pkg::PLAY_W-1:0]        o_played_total
);

    localparam int PW = prst_pkg::DIV_W + 1;

    // Configuration registers.
    logic [prst_pkg::SIZE_W-1:0]  r_buf_bytes;
    logic [prst_pkg::SIZE_W-1:0]  r_frag_bytes;
    logic [prst_pkg::SAMP_W-1:0]  r_samp_bytes;
    logic [prst_pkg::ADDR_W-1:0]  r_loop_start;
    logic                         r_mapped;
    logic                         r_wide;

    // Ring state.
    logic [prst_pkg::OFF_W-1:0]         r_hw_offset, n_hw_offset;
    logic [prst_pkg::OFF_W-1:0]         r_sil_offset, n_sil_offset;
    logic [prst_pkg::CNT_W-1:0]         r_sil_count, n_sil_count;
    logic signed [prst_pkg::FREE_W-1:0] r_free_count, n_free_count;
    logic [prst_pkg::PLAY_W-1:0]        r_played, n_played;

    // Current transaction and intermediate results.
    logic [prst_pkg::FUNC_W-1:0]  r_func;
    logic                         r_running;
    logic [prst_pkg::ADDR_W-1:0]  r_addr;
    logic [prst_pkg::LEN_W-1:0]   r_wlen;
    logic [prst_pkg::OFF_W-1:0]   r_old;
    logic [prst_pkg::OFF_W-1:0]   r_spos;
    logic [prst_pkg::SIZE_W-1:0]  r_quot;
    logic [prst_pkg::OFF_W-1:0]   r_wrap;
    logic                         r_neg;
    logic [prst_pkg::DIV_W-1:0]   r_mag;

    logic [prst_pkg::SIZE_W-1:0]  size;
    logic [prst_pkg::SIZE_W-1:0]  frag;
    logic [prst_pkg::SAMP_W-1:0]  bps;

    logic                         div_done;
    logic [prst_pkg::DIV_W-1:0]   div_dividend;
    logic [prst_pkg::SIZE_W-1:0]  div_divisor;
    logic [prst_pkg::DIV_W-1:0]   div_quot;
    logic [prst_pkg::SIZE_W-1:0]  div_rem;
    logic [prst_pkg::SIZE_W-1:0]  wrap_fix;

    logic signed [PW-1:0]         p_s;
    logic signed [PW-1:0]         p_v;
    logic signed [PW-1:0]         p_negv;

    // Result of the commit step.
    logic signed [prst_pkg::XFER_W-1:0] c_xfer;
    logic                               c_need;
    logic                               c_under;
    logic [prst_pkg::SIZE_W-1:0]        c_acc;
    logic [prst_pkg::FILL_W-1:0]        c_fill;
    logic                               seg_en;
    logic [prst_pkg::OFF_W-1:0]         seg_st;
    logic [prst_pkg::SIZE_W-1:0]        seg_len;
    logic [prst_pkg::SIZE_W-1:0]        room;
    logic [prst_pkg::SIZE_W-1:0]        c_first;
    logic [prst_pkg::SIZE_W-1:0]        c_second;
    logic [prst_pkg::OFF_W-1:0]         pos;
    logic signed [prst_pkg::FREE_W-1:0] diff_s;
    logic [prst_pkg::SIZE_W-1:0]        diff;
    logic signed [prst_pkg::SUM_W-1:0]  free_ext;
    logic signed [prst_pkg::SUM_W-1:0]  pending;
    logic signed [prst_pkg::SUM_W-1:0]  sil_ext;
    logic [prst_pkg::SIZE_W-1:0]        wlen_c;
    logic [prst_pkg::SIZE_W-1:0]        extra;
    logic [prst_pkg::SIZE_W:0]          ssum;

    assign size = prst_pkg::clamp_len(r_buf_bytes);
    assign frag = prst_pkg::clamp_len(r_frag_bytes);
    assign bps  = (r_samp_bytes == '0) ? prst_pkg::SAMP_W'(1) : r_samp_bytes;

    always_comb begin
        div_divisor = size;
        case (i_cmd.job)
            prst_pkg::JOB_OLD:  div_dividend = prst_pkg::DIV_W'(r_hw_offset);
            prst_pkg::JOB_SPOS: div_dividend = prst_pkg::DIV_W'(r_sil_offset);
            prst_pkg::JOB_QUOT: begin
                div_dividend = prst_pkg::DIV_W'(size);
                div_divisor  = prst_pkg::SIZE_W'(bps);
            end
            default:            div_dividend = r_mag;
        endcase
    end

    prst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // A negative operand leaves a remainder that is folded back into the ring.
    assign wrap_fix = (r_neg && (div_rem != '0)) ? (size - div_rem) : div_rem;

    // Operand of the final reduction, built from captured values.
    always_comb begin
        p_s = $signed(PW'(r_addr)) - $signed(PW'(r_loop_start));
        if (r_addr < r_loop_start) begin
            p_s = p_s + $signed(PW'(r_quot));
        end
        case (r_func)
            prst_pkg::FN_POS: begin
                p_v = (bps[0] ? p_s : '0)
                    + (bps[1] ? (p_s <<< 1) : '0)
                    + (bps[2] ? (p_s <<< 2) : '0);
            end
            prst_pkg::FN_WRITE: p_v = $signed(PW'(r_spos)) - $signed(PW'(r_sil_count));
            prst_pkg::FN_FILL:  p_v = $signed(PW'(r_spos)) + $signed(PW'(frag));
            default:            p_v = '0;
        endcase
        p_negv = -p_v;
    end

    always_comb begin
        n_hw_offset  = r_hw_offset;
        n_sil_offset = r_sil_offset;
        n_sil_count  = r_sil_count;
        n_free_count = r_free_count;
        n_played     = r_played;
        c_xfer       = '0;
        c_need       = 1'b0;
        c_under      = 1'b0;
        c_acc        = '0;
        c_fill       = '0;
        seg_en       = 1'b0;
        seg_st       = '0;
        seg_len      = '0;
        free_ext     = prst_pkg::SUM_W'(r_free_count);
        sil_ext      = $signed(prst_pkg::SUM_W'(r_sil_count));
        pending      = $signed(prst_pkg::SUM_W'(size)) - free_ext;
        pos          = r_running ? r_wrap : r_old;
        diff_s       = $signed(prst_pkg::FREE_W'(pos)) - $signed(prst_pkg::FREE_W'(r_old));
        diff         = (diff_s < 0) ? prst_pkg::SIZE_W'(diff_s + $signed(prst_pkg::FREE_W'(size)))
                                    : prst_pkg::SIZE_W'(diff_s);
        wlen_c       = (r_wlen < prst_pkg::LEN_W'(size)) ? prst_pkg::SIZE_W'(r_wlen) : size;
        extra        = wlen_c - r_sil_count;
        ssum         = prst_pkg::SIZE_W'(r_spos) + extra;
        case (r_func)
            prst_pkg::FN_REOPEN: begin
                n_hw_offset  = '0;
                n_sil_offset = '0;
                n_sil_count  = '0;
                n_free_count = $signed(prst_pkg::FREE_W'(size));
            end
            prst_pkg::FN_POS: begin
                n_played     = r_played + prst_pkg::PLAY_W'(diff);
                n_free_count = prst_pkg::sat_free(free_ext + $signed(prst_pkg::SUM_W'(diff)));
                n_hw_offset  = pos;
            end
            prst_pkg::FN_QUERY: begin
                if (r_mapped) begin
                    c_xfer = prst_pkg::XFER_W'(r_free_count);
                end else begin
                    c_need = (pending < $signed(prst_pkg::SUM_W'(frag)));
                    if (pending > sil_ext) begin
                        c_xfer = prst_pkg::XFER_W'(free_ext + sil_ext);
                    end else begin
                        c_xfer      = $signed(prst_pkg::XFER_W'(size));
                        n_sil_count = prst_pkg::CNT_W'(pending);
                        if (pending < 0) begin
                            n_sil_offset = r_old;
                            n_sil_count  = '0;
                            n_free_count = $signed(prst_pkg::FREE_W'(size));
                            c_under      = 1'b1;
                        end
                    end
                end
            end
            prst_pkg::FN_WRITE: begin
                c_acc = wlen_c;
                if (wlen_c != '0) begin
                    seg_en  = 1'b1;
                    seg_st  = r_wrap;
                    seg_len = wlen_c;
                    if (wlen_c > r_sil_count) begin
                        n_sil_offset = (ssum >= prst_pkg::SIZE_W'(size))
                                     ? prst_pkg::OFF_W'(ssum - prst_pkg::SIZE_W'(size))
                                     : prst_pkg::OFF_W'(ssum);
                        n_free_count = prst_pkg::sat_free(free_ext
                                     - $signed(prst_pkg::SUM_W'(extra)));
                        n_sil_count  = '0;
                    end else begin
                        n_sil_count  = r_sil_count - wlen_c;
                    end
                end
            end
            prst_pkg::FN_FILL: begin
                c_fill       = r_wide ? prst_pkg::FILL_WIDE : prst_pkg::FILL_NARROW;
                n_sil_count  = prst_pkg::sat_sil(prst_pkg::SIZE_W'(r_sil_count)
                             + prst_pkg::SIZE_W'(frag) + (prst_pkg::CNT_W+1)'(0));
                n_free_count = prst_pkg::sat_free(free_ext - $signed(prst_pkg::SUM_W'(frag)));
                n_sil_offset = r_wrap;
                seg_en       = 1'b1;
                seg_st       = r_spos;
                seg_len      = frag;
            end
            default: begin
            end
        endcase
        // Split the touched span at the end of the ring.
        room = size - prst_pkg::SIZE_W'(seg_st);
        if (!seg_en) begin
            c_first  = '0;
            c_second = '0;
        end else if (seg_len > room) begin
            c_first  = room;
            c_second = seg_len - room;
        end else begin
            c_first  = seg_len;
            c_second = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_bytes  <= prst_pkg::BUF_MAX_V;
            r_frag_bytes <= prst_pkg::SIZE_W'(4096);
            r_samp_bytes <= prst_pkg::SAMP_W'(4);
            r_loop_start <= '0;
            r_mapped     <= 1'b0;
            r_wide       <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                prst_pkg::CFG_BUFFER_BYTES:   r_buf_bytes  <= i_cfg_data[prst_pkg::SIZE_W-1:0];
                prst_pkg::CFG_FRAGMENT_BYTES: r_frag_bytes <= i_cfg_data[prst_pkg::SIZE_W-1:0];
                prst_pkg::CFG_SAMPLE_BYTES:   r_samp_bytes <= i_cfg_data[prst_pkg::SAMP_W-1:0];
                prst_pkg::CFG_LOOP_START:     r_loop_start <= i_cfg_data[prst_pkg::ADDR_W-1:0];
                prst_pkg::CFG_MAPPED_MODE:    r_mapped     <= i_cfg_data[0];
                prst_pkg::CFG_WIDE_SAMPLES:   r_wide       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw_offset  <= '0;
            r_sil_offset <= '0;
            r_sil_count  <= '0;
            r_free_count <= $signed(prst_pkg::FREE_W'(prst_pkg::BUF_MAX));
            r_played     <= '0;
        end else if (i_cmd.commit) begin
            r_hw_offset  <= n_hw_offset;
            r_sil_offset <= n_sil_offset;
            r_sil_count  <= n_sil_count;
            r_free_count <= n_free_count;
            r_played     <= n_played;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_running <= i_running;
            r_addr    <= i_hw_addr;
            r_wlen    <= i_write_len;
        end
        if (i_cmd.capture) begin
            case (i_cmd.job)
                prst_pkg::JOB_OLD:  r_old  <= div_rem[prst_pkg::OFF_W-1:0];
                prst_pkg::JOB_SPOS: r_spos <= div_rem[prst_pkg::OFF_W-1:0];
                prst_pkg::JOB_QUOT: r_quot <= div_quot[prst_pkg::SIZE_W-1:0];
                default:            r_wrap <= wrap_fix[prst_pkg::OFF_W-1:0];
            endcase
        end
        if (i_cmd.prep) begin
            r_neg <= p_v[PW-1];
            r_mag <= p_v[PW-1] ? p_negv[prst_pkg::DIV_W-1:0] : p_v[prst_pkg::DIV_W-1:0];
        end
        if (i_cmd.commit) begin
            o_xfer_size      <= c_xfer;
            o_need_silence   <= c_need;
            o_underrun       <= c_under;
            o_accepted_len   <= c_acc;
            o_seg_start      <= seg_en ? seg_st : '0;
            o_seg_first_len  <= c_first;
            o_seg_second_len <= c_second;
            o_fill_byte      <= c_fill;
            o_played_total   <= n_played;
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.func     = r_func;
        o_stat.running  = r_running;
        o_stat.div_done = div_done;
    end

endmodule

### rtl/playback_ring_silence_tracker.sv
// Pointer and counter bookkeeping for a circular playback buffer that is padded with silence.
// Input channel: i_in_valid / o_in_stall carry one operation per transaction (func, running,
// hw_addr, write_len). Output channel: o_out_valid / i_out_stall return exactly one result
// transaction per operation, in order. Configuration is a plain write port (i_cfg_we,
// i_cfg_idx, i_cfg_data); the user must write it only while the block is idle, as the
// block itself does not enforce this. Every offset is reduced modulo the ring size by one
// shared restoring divider that produces one quotient bit per cycle. Reopen and unused
// codes use no division, a query or a stopped position update one, a host write or
// silence fill two, and a running position update three; the latter two add a preparation
// state before the final reduction.
// o_in_stall is high from the cycle after acceptance until the block is idle again.
// The result sits in an output register, so a new transaction is accepted while it waits;
// if the receiver still stalls when the next result is ready, that one waits unwritten.
// Synchronous active-low reset returns the configuration registers to their defaults,
// empties the ring (full free count, no silence pending) and clears the played total.
module playback_ring_silence_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [prst_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [prst_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [prst_pkg::FUNC_W-1:0]        i_func,
    input  logic                               i_running,
    input  logic [prst_pkg::ADDR_W-1:0]        i_hw_addr,
    input  logic [prst_pkg::LEN_W-1:0]         i_write_len,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [prst_pkg::XFER_W-1:0] o_xfer_size,
    output logic                               o_need_silence,
    output logic                               o_underrun,
    output logic [prst_pkg::SIZE_W-1:0]        o_accepted_len,
    output logic [prst_pkg::OFF_W-1:0]         o_seg_start,
    output logic [prst_pkg::SIZE_W-1:0]        o_seg_first_len,
    output logic [prst_pkg::SIZE_W-1:0]        o_seg_second_len,
    output logic [prst_pkg::FILL_W-1:0]        o_fill_byte,
    output logic [prst_pkg::PLAY_W-1:0]        o_played_total
);

    prst_pkg::t_cmd  cmd;
    prst_pkg::t_stat stat;

    // The controller sequences the divider jobs that each operation needs and
    // decides when the ring state and output register are updated.
    prst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath holds the configuration, the ring state, the divider and the
    // output register.
    prst_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_running        (i_running),
        .i_hw_addr        (i_hw_addr),
        .i_write_len      (i_write_len),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_xfer_size      (o_xfer_size),
        .o_need_silence   (o_need_silence),
        .o_underrun       (o_underrun),
        .o_accepted_len   (o_accepted_len),
        .o_seg_start      (o_seg_start),
        .o_seg_first_len  (o_seg_first_len),
        .o_seg_second_len (o_seg_second_len),
        .o_fill_byte      (o_fill_byte),
        .o_played_total   (o_played_total)
    );

    // An accepted transaction keeps the input side closed on the following cycle.
    a_load_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> o_in_stall)
        else $error("input not stalled after a transaction was taken");

    // A committed result is presented on the output channel on the next cycle.
    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out_valid)
        else $error("committed result not presented");

    // Each transaction commits once only.
    a_single_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> !cmd.commit)
        else $error("result committed twice");

    // Divider results are taken only when the divider reports completion.
    a_capture_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |-> stat.div_done)
        else $error("divider result taken before completion");

endmodule
